// ===== sv/tme_pkg.sv =====
// Shared types, codes and constants of the tour move engine.
`default_nettype none
package tme_pkg;

	localparam int NODE_W = 6;
	localparam int MODE_W = 3;
	localparam int IN_DIST_W = 16;
	localparam int GAIN_W = 19;
	localparam int LEN_W = 22;
	localparam int STAT_W = 2;
	localparam int NC_W = 7;
	localparam int THR_W = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [LEN_W-1:0] LEN_MAX = 22'h3FFFFF;

	localparam logic [MODE_W-1:0] MODE_WR_DIST = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WR_SUCC = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CHECK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_EVAL_2OPT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EVAL_INS = 3'd4;
	localparam logic [MODE_W-1:0] MODE_APPLY = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RD_SUCC = 3'd7;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_PICK = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_PENDING = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_TOUR = 2'd3;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_2OPT = 2'd1;
	localparam logic [1:0] PEND_INS = 2'd2;

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef struct packed {
		logic [NC_W-1:0]  node_count;
		logic [THR_W-1:0] threshold;
		logic             wr;
	} tme_cfg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_RD_GOT, S_SC_RD, S_SC_CHK, S_SC_ADD, S_DISPATCH,
		S_PK_RD_A, S_PK_RD_B, S_PK_GOT_B, S_TO_TEST, S_TO_STEP,
		S_DG_RD, S_DG_ACC, S_GAIN_END,
		S_SR_RD_I, S_SR_GOT_I, S_SR_RD_J, S_SR_GOT_J, S_SR_NEXT, S_SR_END,
		S_AP_START, S_AP_RD0, S_AP_N0, S_AP_TEST, S_AP_W, S_AP_FIN1, S_AP_FIN2,
		S_AP_I0, S_AP_I1, S_AP_I2, S_FIN
	} tme_state_t;

endpackage
`default_nettype wire

// ===== sv/tme_cfg.sv =====
// APB register block: node count and search threshold.
`default_nettype none
module tme_cfg import tme_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output tme_cfg_t          cfg
);

	logic [NC_W-1:0]  node_count_q;
	logic [THR_W-1:0] threshold_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NC_W'(64);
			threshold_q <= THR_W'(1);
		end else if (wr) begin
			if (paddr[2] == REG_THRESHOLD) begin
				threshold_q <= pwdata[THR_W-1:0];
			end else begin
				node_count_q <= pwdata[NC_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_THRESHOLD) begin
			prdata = DATA_W'(threshold_q);
		end else begin
			prdata = DATA_W'(node_count_q);
		end
	end

	assign cfg.node_count = node_count_q;
	assign cfg.threshold = threshold_q;
	assign cfg.wr = wr;

endmodule
`default_nettype wire

// ===== sv/tme_engine.sv =====
// Move sequencer with the node memory (successor, predecessor) and the distance memory.
`default_nettype none
module tme_engine import tme_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int DIST_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MODE_W-1:0]    mode,
	input  logic [NODE_W-1:0]    node_a,
	input  logic [NODE_W-1:0]    node_b,
	input  logic [IN_DIST_W-1:0] distance,
	input  tme_cfg_t             cfg,
	output logic                 busy,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [GAIN_W-1:0]    gain,
	output logic [LEN_W-1:0]     tour_len,
	output logic [NODE_W-1:0]    node_out,
	output logic                 moved
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int VW = (NW > NODE_W) ? NW : NODE_W;
	localparam int NNW = $clog2(MAX_NODES + 1);
	localparam int KW = (VW > NNW) ? VW : NNW;
	localparam int GW = DIST_BITS + 3;
	localparam int CW = (GW > GAIN_W) ? GW : GAIN_W;
	localparam int DAW = $clog2(MAX_NODES * MAX_NODES);
	localparam int SW = ((LEN_W > DIST_BITS) ? LEN_W : DIST_BITS) + 1;
	localparam int DXW = (IN_DIST_W > DIST_BITS) ? IN_DIST_W : DIST_BITS;
	localparam logic [VW:0] MAXV = (VW+1)'(MAX_NODES);
	localparam logic [8:0] MAXC = 9'(MAX_NODES);

	// memories
	logic [2*VW-1:0]      nd_mem [MAX_NODES];
	logic [DIST_BITS-1:0] d_mem [MAX_NODES*MAX_NODES];
	logic [NW-1:0]        nm_ra, nm_wa;
	logic [VW-1:0]        nm_wd;
	logic                 nm_we_s, nm_we_p;
	logic [2*VW-1:0]      nm_rd;
	logic [DAW-1:0]       dm_ra, dm_wa;
	logic                 dm_we;
	logic [DIST_BITS-1:0] dm_rd, dm_wd;

	always_ff @(posedge clk) begin
		if (nm_we_s) begin
			nd_mem[nm_wa][VW-1:0] <= nm_wd;
		end
		if (nm_we_p) begin
			nd_mem[nm_wa][2*VW-1:VW] <= nm_wd;
		end
		nm_rd <= nd_mem[nm_ra];
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			d_mem[dm_wa] <= dm_wd;
		end
		dm_rd <= d_mem[dm_ra];
	end

	logic [VW-1:0] rd_succ, rd_pred;
	assign rd_succ = nm_rd[VW-1:0];
	assign rd_pred = nm_rd[2*VW-1:VW];

	function automatic logic [DAW-1:0] daddr(input logic [VW-1:0] x, input logic [VW-1:0] y);
		return DAW'(DAW'(x[NW-1:0]) * DAW'(MAX_NODES)) + DAW'(y[NW-1:0]);
	endfunction

	// state
	tme_state_t st_q, st_d;
	logic [MODE_W-1:0]    mode_q;
	logic [VW-1:0]        a_q, b_q, cur_q, nxt_q, s_q;
	logic [IN_DIST_W-1:0] dist_in_q;
	logic [NNW-1:0]       i_q, j_q, steps_q;
	logic [VW-1:0]        c_q [5];
	logic [VW-1:0]        pn_q [5];
	logic [VW-1:0]        keep_q [5];
	logic [1:0]           pk_q;
	logic [LEN_W-1:0]     acc_q, len_q;
	logic signed [GW-1:0] g_q, best_q;
	logic                 found_q, inval_q, do_len_q, len_only_q;
	logic [MAX_NODES-1:0] seen_q;
	logic [2:0]           k_q;
	logic [STAT_W-1:0]    status_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [NODE_W-1:0]    node_out_q;
	logic                 moved_q;

	// active node count
	logic [8:0]     n9;
	logic [NNW-1:0] n_act, n_m1;
	always_comb begin
		if (cfg.node_count < NC_W'(2)) begin
			n9 = 9'd2;
		end else if (9'(cfg.node_count) > MAXC) begin
			n9 = MAXC;
		end else begin
			n9 = 9'(cfg.node_count);
		end
	end
	assign n_act = n9[NNW-1:0];
	assign n_m1 = n_act - NNW'(1);

	function automatic logic ge_n(input logic [VW-1:0] v, input logic [NNW-1:0] nn);
		return KW'(v) >= KW'(nn);
	endfunction

	logic [VW-1:0] i_v, j_v;
	logic          last_i, last_j, pick_bad, sc_bad, skip_pair, is_2opt;
	assign i_v = VW'(i_q);
	assign j_v = VW'(j_q);
	assign last_i = (i_q == n_m1);
	assign last_j = (j_q == n_m1);
	assign is_2opt = (mode_q == MODE_EVAL_2OPT);
	assign pick_bad = (a_q == b_q) || ge_n(a_q, n_act) || ge_n(b_q, n_act);
	assign sc_bad = ge_n(rd_succ, n_act) || (rd_succ == i_v) || seen_q[rd_succ[NW-1:0]];
	assign skip_pair = (i_v == j_v) || (c_q[1] == j_v) || (rd_succ == i_v);

	// gain term selection: first terms add, the rest subtract
	logic [VW-1:0] tx, ty;
	logic          tneg, tlast;
	always_comb begin
		tx = c_q[0];
		ty = c_q[1];
		if (is_2opt) begin
			tneg = (k_q >= 3'd2);
			tlast = (k_q == 3'd3);
			case (k_q)
				3'd0: begin tx = c_q[0]; ty = c_q[1]; end
				3'd1: begin tx = c_q[2]; ty = c_q[3]; end
				3'd2: begin tx = c_q[0]; ty = c_q[2]; end
				default: begin tx = c_q[1]; ty = c_q[3]; end
			endcase
		end else begin
			tneg = (k_q >= 3'd3);
			tlast = (k_q == 3'd5);
			case (k_q)
				3'd0: begin tx = c_q[0]; ty = c_q[1]; end
				3'd1: begin tx = c_q[2]; ty = c_q[3]; end
				3'd2: begin tx = c_q[3]; ty = c_q[4]; end
				3'd3: begin tx = c_q[0]; ty = c_q[3]; end
				3'd4: begin tx = c_q[2]; ty = c_q[4]; end
				default: begin tx = c_q[3]; ty = c_q[1]; end
			endcase
		end
	end

	logic signed [GW-1:0] d_term;
	logic signed [CW-1:0] g_ext, best_ext, thr_ext;
	logic [SW-1:0]        sum;
	logic [DXW-1:0]       dist_ext;
	assign d_term = $signed(GW'(dm_rd));
	assign g_ext = CW'(g_q);
	assign best_ext = CW'(best_q);
	assign thr_ext = $signed(CW'(cfg.threshold));
	assign sum = SW'(acc_q) + SW'(dm_rd);
	assign dist_ext = DXW'(dist_in_q);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (start) st_d = S_DECODE;
			S_DECODE: begin
				case (mode_q)
					MODE_CHECK, MODE_EVAL_2OPT, MODE_EVAL_INS, MODE_SEARCH: st_d = S_SC_RD;
					MODE_APPLY: st_d = (pk_q == PEND_NONE) ? S_FIN : S_AP_START;
					MODE_RD_SUCC: st_d = ge_n(a_q, n_act) ? S_FIN : S_RD_GOT;
					default: st_d = S_FIN;
				endcase
			end
			S_RD_GOT: st_d = S_FIN;
			S_SC_RD: st_d = S_SC_CHK;
			S_SC_CHK: begin
				if (do_len_q) st_d = S_SC_ADD;
				else st_d = last_i ? S_DISPATCH : S_SC_RD;
			end
			S_SC_ADD: st_d = last_i ? S_DISPATCH : S_SC_RD;
			S_DISPATCH: begin
				if (len_only_q || mode_q == MODE_CHECK || inval_q) st_d = S_FIN;
				else if (mode_q == MODE_SEARCH) st_d = S_SR_RD_I;
				else st_d = pick_bad ? S_FIN : S_PK_RD_A;
			end
			S_PK_RD_A: st_d = S_PK_RD_B;
			S_PK_RD_B: st_d = S_PK_GOT_B;
			S_PK_GOT_B: begin
				if (is_2opt) st_d = S_TO_TEST;
				else if (c_q[1] == b_q || rd_succ == a_q) st_d = S_FIN;
				else st_d = S_DG_RD;
			end
			S_TO_TEST: begin
				if (cur_q == b_q) st_d = S_DG_RD;
				else if (cur_q == a_q || steps_q >= n_act) st_d = S_FIN;
				else st_d = S_TO_STEP;
			end
			S_TO_STEP: st_d = S_TO_TEST;
			S_DG_RD: st_d = S_DG_ACC;
			S_DG_ACC: st_d = tlast ? S_GAIN_END : S_DG_RD;
			S_GAIN_END: st_d = (mode_q == MODE_SEARCH) ? S_SR_NEXT : S_FIN;
			S_SR_RD_I: st_d = S_SR_GOT_I;
			S_SR_GOT_I: st_d = S_SR_RD_J;
			S_SR_RD_J: st_d = S_SR_GOT_J;
			S_SR_GOT_J: st_d = skip_pair ? S_SR_NEXT : S_DG_RD;
			S_SR_NEXT: begin
				if (!last_j) st_d = S_SR_RD_J;
				else st_d = last_i ? S_SR_END : S_SR_RD_I;
			end
			S_SR_END: st_d = (found_q && best_ext > thr_ext) ? S_AP_START : S_FIN;
			S_AP_START: st_d = (pk_q == PEND_2OPT) ? S_AP_RD0 : S_AP_I0;
			S_AP_RD0: st_d = S_AP_N0;
			S_AP_N0: st_d = S_AP_TEST;
			S_AP_TEST: st_d = (cur_q == pn_q[2] || steps_q >= n_act) ? S_AP_FIN1 : S_AP_W;
			S_AP_W: st_d = S_AP_TEST;
			S_AP_FIN1: st_d = S_AP_FIN2;
			S_AP_FIN2: st_d = S_SC_RD;
			S_AP_I0: st_d = S_AP_I1;
			S_AP_I1: st_d = S_AP_I2;
			S_AP_I2: st_d = S_SC_RD;
			S_FIN: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		nm_ra = '0;
		nm_wa = '0;
		nm_wd = '0;
		nm_we_s = 1'b0;
		nm_we_p = 1'b0;
		dm_ra = '0;
		dm_wa = daddr(a_q, b_q);
		dm_wd = dist_ext[DIST_BITS-1:0];
		dm_we = 1'b0;
		case (st_q)
			S_DECODE: begin
				nm_ra = a_q[NW-1:0];
				nm_wa = a_q[NW-1:0];
				nm_wd = b_q;
				if (mode_q == MODE_WR_DIST) dm_we = ({1'b0, a_q} < MAXV) && ({1'b0, b_q} < MAXV);
				if (mode_q == MODE_WR_SUCC) nm_we_s = ({1'b0, a_q} < MAXV);
			end
			S_SC_RD: nm_ra = i_q[NW-1:0];
			S_SC_CHK: begin
				nm_wa = rd_succ[NW-1:0];
				nm_wd = i_v;
				nm_we_p = !sc_bad;
				dm_ra = daddr(i_v, rd_succ);
			end
			S_PK_RD_A: nm_ra = a_q[NW-1:0];
			S_PK_RD_B: nm_ra = b_q[NW-1:0];
			S_TO_TEST: nm_ra = cur_q[NW-1:0];
			S_DG_RD: dm_ra = daddr(tx, ty);
			S_SR_RD_I: nm_ra = i_q[NW-1:0];
			S_SR_RD_J: nm_ra = j_q[NW-1:0];
			S_AP_RD0: nm_ra = pn_q[1][NW-1:0];
			S_AP_TEST: nm_ra = nxt_q[NW-1:0];
			S_AP_W: begin
				nm_wa = nxt_q[NW-1:0];
				nm_wd = cur_q;
				nm_we_s = 1'b1;
			end
			S_AP_FIN1: begin
				nm_wa = pn_q[0][NW-1:0];
				nm_wd = pn_q[2];
				nm_we_s = 1'b1;
			end
			S_AP_FIN2: begin
				nm_wa = pn_q[1][NW-1:0];
				nm_wd = pn_q[3];
				nm_we_s = 1'b1;
			end
			S_AP_I0: begin
				nm_wa = pn_q[0][NW-1:0];
				nm_wd = pn_q[3];
				nm_we_s = 1'b1;
			end
			S_AP_I1: begin
				nm_wa = pn_q[2][NW-1:0];
				nm_wd = pn_q[4];
				nm_we_s = 1'b1;
			end
			S_AP_I2: begin
				nm_wa = pn_q[3][NW-1:0];
				nm_wd = pn_q[1];
				nm_we_s = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pk_q <= PEND_NONE;
			len_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg.wr) pk_q <= PEND_NONE;
			case (st_q)
				S_DECODE: if (mode_q == MODE_WR_SUCC && ({1'b0, a_q} < MAXV)) pk_q <= PEND_NONE;
				S_DISPATCH: if (do_len_q) len_q <= acc_q;
				S_GAIN_END: if (mode_q != MODE_SEARCH) pk_q <= is_2opt ? PEND_2OPT : PEND_INS;
				S_SR_END: if (found_q) pk_q <= PEND_INS;
				S_AP_START: pk_q <= PEND_NONE;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				mode_q <= mode;
				a_q <= VW'(node_a);
				b_q <= VW'(node_b);
				dist_in_q <= distance;
			end
			S_DECODE: begin
				status_q <= STAT_OK;
				gain_q <= '0;
				node_out_q <= '0;
				moved_q <= 1'b0;
				i_q <= '0;
				acc_q <= '0;
				inval_q <= 1'b0;
				seen_q <= '0;
				do_len_q <= (mode_q == MODE_CHECK);
				len_only_q <= 1'b0;
				if (mode_q == MODE_APPLY && pk_q == PEND_NONE) status_q <= STAT_NO_PENDING;
				if (mode_q == MODE_RD_SUCC && ge_n(a_q, n_act)) status_q <= STAT_BAD_PICK;
			end
			S_RD_GOT: node_out_q <= rd_succ[NODE_W-1:0];
			S_SC_CHK: begin
				s_q <= rd_succ;
				if (sc_bad) begin
					inval_q <= 1'b1;
				end else begin
					seen_q[rd_succ[NW-1:0]] <= 1'b1;
				end
				if (!do_len_q) i_q <= i_q + NNW'(1);
			end
			S_SC_ADD: begin
				if ({1'b0, s_q} < MAXV) begin
					acc_q <= (sum > SW'(LEN_MAX)) ? LEN_MAX : sum[LEN_W-1:0];
				end
				i_q <= i_q + NNW'(1);
			end
			S_DISPATCH: begin
				i_q <= '0;
				found_q <= 1'b0;
				best_q <= {{(GW-1){1'b1}}, 1'b0};
				if (!len_only_q) begin
					if (inval_q && mode_q != MODE_CHECK) status_q <= STAT_BAD_TOUR;
					else if (inval_q) status_q <= STAT_BAD_TOUR;
					else if (mode_q != MODE_CHECK && mode_q != MODE_SEARCH && pick_bad)
						status_q <= STAT_BAD_PICK;
				end
			end
			S_PK_RD_B: c_q[1] <= rd_succ;
			S_PK_GOT_B: begin
				c_q[0] <= a_q;
				g_q <= '0;
				k_q <= '0;
				cur_q <= c_q[1];
				steps_q <= '0;
				if (is_2opt) begin
					c_q[2] <= b_q;
					c_q[3] <= rd_succ;
					c_q[4] <= '0;
				end else begin
					c_q[2] <= rd_pred;
					c_q[3] <= b_q;
					c_q[4] <= rd_succ;
					if (c_q[1] == b_q || rd_succ == a_q) status_q <= STAT_BAD_PICK;
				end
			end
			S_TO_TEST: if (cur_q != b_q && (cur_q == a_q || steps_q >= n_act)) status_q <= STAT_BAD_PICK;
			S_TO_STEP: begin
				cur_q <= rd_succ;
				steps_q <= steps_q + NNW'(1);
			end
			S_DG_ACC: begin
				g_q <= tneg ? g_q - d_term : g_q + d_term;
				k_q <= tlast ? 3'd0 : k_q + 3'd1;
			end
			S_GAIN_END: begin
				if (mode_q == MODE_SEARCH) begin
					if (g_q > best_q) begin
						best_q <= g_q;
						found_q <= 1'b1;
						keep_q <= c_q;
					end
				end else begin
					gain_q <= g_ext[GAIN_W-1:0];
					pn_q <= c_q;
				end
			end
			S_SR_GOT_I: begin
				c_q[0] <= i_v;
				c_q[1] <= rd_succ;
				j_q <= '0;
			end
			S_SR_GOT_J: begin
				c_q[2] <= rd_pred;
				c_q[3] <= j_v;
				c_q[4] <= rd_succ;
				g_q <= '0;
				k_q <= '0;
			end
			S_SR_NEXT: begin
				if (!last_j) begin
					j_q <= j_q + NNW'(1);
				end else begin
					i_q <= i_q + NNW'(1);
				end
			end
			S_SR_END: begin
				if (found_q) begin
					gain_q <= best_ext[GAIN_W-1:0];
					pn_q <= keep_q;
					if (best_ext > thr_ext) begin
						moved_q <= 1'b1;
						node_out_q <= keep_q[3][NODE_W-1:0];
					end
				end
			end
			S_AP_START: begin
				cur_q <= pn_q[1];
				steps_q <= '0;
			end
			S_AP_N0: nxt_q <= rd_succ;
			S_AP_W: begin
				nxt_q <= rd_succ;
				cur_q <= nxt_q;
				steps_q <= steps_q + NNW'(1);
			end
			S_AP_FIN2, S_AP_I2: begin
				i_q <= '0;
				acc_q <= '0;
				inval_q <= 1'b0;
				seen_q <= '0;
				do_len_q <= 1'b1;
				len_only_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_FIN);
	assign status = status_q;
	assign gain = gain_q;
	assign tour_len = len_q;
	assign node_out = node_out_q;
	assign moved = moved_q;

endmodule
`default_nettype wire

// ===== sv/tsp_tour_move_engine_core.sv =====
// Top level of the tour move engine: register port and move sequencer.
//
// channel   signals                                   handshake
// command   start, mode, node_a, node_b, distance     start & !busy
// result    status, gain, tour_len, node_out, moved   done, one cycle
// config    psel, penable, pwrite, paddr, pwdata      APB write, pready tied high
//
// Table writes pass through the decode and finish states, successor reads through decode,
// read and finish states. Validation and length scans walk the node memory city by city;
// 2-opt adds a walk along the tour, a 2-opt apply a walk over the reversed segment, and
// every apply a length scan; a search round tries every pair of cities. Each memory has a
// single read port. Reset clears control state; table contents are undefined until written.
// The result cannot be stalled; busy stays high while done is shown and falls as the engine goes idle.
`default_nettype none
module tsp_tour_move_engine_core import tme_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int DIST_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [MODE_W-1:0]    mode,
	input  logic [NODE_W-1:0]    node_a,
	input  logic [NODE_W-1:0]    node_b,
	input  logic [IN_DIST_W-1:0] distance,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [GAIN_W-1:0]    gain,
	output logic [LEN_W-1:0]     tour_len,
	output logic [NODE_W-1:0]    node_out,
	output logic                 moved,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	tme_cfg_t cfg;

	tme_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tme_engine #(
		.MAX_NODES (MAX_NODES),
		.DIST_BITS (DIST_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.node_a   (node_a),
		.node_b   (node_b),
		.distance (distance),
		.cfg      (cfg),
		.busy     (busy),
		.done     (done),
		.status   (status),
		.gain     (gain),
		.tour_len (tour_len),
		.node_out (node_out),
		.moved    (moved)
	);

endmodule
`default_nettype wire

// ===== sv/tme_chk.sv =====
// Port-level checks of the tour move engine, bound to the top level.
`default_nettype none
module tme_chk import tme_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [STAT_W-1:0] status,
	input logic              moved,
	input logic              psel,
	input logic              penable,
	input logic              pready
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result word shown while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result word held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command word taken but engine not busy");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && moved |-> status == STAT_OK)
		else $error("move applied with error status");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("APB access stalled");

endmodule

bind tsp_tour_move_engine_core tme_chk u_tme_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.status  (status),
	.moved   (moved),
	.psel    (psel),
	.penable (penable),
	.pready  (pready)
);
`default_nettype wire
